/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL; they compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define IHSP_ASSERT(lbl, clk_sig, rstn_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error("assertion failed");
`define IHSP_ASSERT_RST(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("assertion failed during reset");
`else
`define IHSP_ASSERT(lbl, clk_sig, rstn_sig, prop)
`define IHSP_ASSERT_RST(lbl, clk_sig, prop)
`endif
`endif

/* hw/rtl/ihsp_pkg.sv */
// Types and constants of the image header size parser.
`default_nettype none
package ihsp_pkg;

  localparam int POS_BITS = 24;
  localparam int LEN_BITS = 24;
  localparam int CMP_W    = ((POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS) + 2;
  localparam int SEG_BITS = 16;
  localparam int DIM_BITS = 32;
  localparam int OUT_BITS = 72;

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] JPEG_SOI  = 8'hD8;
  localparam logic [7:0] JPEG_SOF0 = 8'hC0;
  localparam logic [7:0] JPEG_EOI  = 8'hD9;
  localparam logic [7:0] JPEG_SOS  = 8'hDA;
  localparam logic [31:0] PNG_SIG  = 32'h8950_4E47;
  localparam logic [31:0] PNG_IHDR = 32'h4948_4452;

  localparam int PNG_MIN_LEN   = 24;
  localparam int PNG_TYPE_POS  = 12;
  localparam int PNG_TYPE_END  = 15;
  localparam int PNG_WIDTH_POS = 16;
  localparam int PNG_WIDTH_END = 19;
  localparam int PNG_HGT_POS   = 20;
  localparam int PNG_HGT_END   = 23;
  localparam int HEAD_MIN_LEN  = 4;

  typedef enum logic [3:0] {
    PH_HEAD   = 4'd0,
    PH_JSEG   = 4'd1,
    PH_JMARK  = 4'd2,
    PH_JLENHI = 4'd3,
    PH_JLENLO = 4'd4,
    PH_JSOF   = 4'd5,
    PH_PNG    = 4'd6,
    PH_DRAIN  = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    FMT_JPEG    = 2'd0,
    FMT_PNG     = 2'd1,
    FMT_UNKNOWN = 2'd2
  } format_t;

  typedef enum logic [2:0] {
    ST_SIZE_FOUND   = 3'd0,
    ST_OK_NO_SIZE   = 3'd1,
    ST_UNKNOWN_FMT  = 3'd2,
    ST_MARKER_MISS  = 3'd3,
    ST_INCOMPLETE   = 3'd4,
    ST_SCAN_FIRST   = 3'd5,
    ST_PNG_SHORT    = 3'd6,
    ST_NO_IHDR      = 3'd7
  } status_t;

  // Packed so that format sits in the lowest bits.
  typedef struct packed {
    logic [DIM_BITS-1:0] image_height;
    logic [DIM_BITS-1:0] image_width;
    status_t             status;
    format_t             format;
  } result_t;

  localparam int RES_BITS = $bits(result_t);

endpackage
`default_nettype wire

/* hw/rtl/image_header_size_parser.sv */
// A result goes to out_* (or to the skid register in a stall) when its last byte is taken.
// Throughput: one byte per cycle; in_tready drops only while both the output
// register and the skid register hold results that the sink has not taken.
// Reset: synchronous, active low; clears the parse phase, byte position, signature,
// total_length and both result valid flags; the other parse registers are loaded before use.
`default_nettype none
`include "assert_macros.svh"
module image_header_size_parser (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [ihsp_pkg::LEN_BITS-1:0] cfg_wr_data,   // total_length
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7:0]                   in_tdata,      // [7:0] data_byte
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [1:0] format, [4:2] status, [36:5] image_width, [68:37] image_height, rest zero
  output logic [ihsp_pkg::OUT_BITS-1:0]     out_tdata
);
  import ihsp_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [POS_BITS-1:0]  nseg_r, nseg_nxt;
  logic [LEN_BITS-1:0]  len_r;
  logic [31:0]          sig_r, sig_nxt;
  logic [7:0]           marker_r, marker_nxt;
  logic [7:0]           seg_hi_r, seg_hi_nxt;
  logic [DIM_BITS-1:0]  wacc_r, wacc_nxt;
  logic [DIM_BITS-1:0]  hacc_r, hacc_nxt;

  logic                 out_valid_r, skid_valid_r;
  result_t              out_r, skid_r;

  logic                 accept, pop, got;
  result_t              res;
  logic [7:0]           b;
  logic [CMP_W-1:0]     pos_c, len_c, nseg_c, seg_end;
  logic                 file_end;
  logic [SEG_BITS-1:0]  seglen;
  logic [POS_BITS-1:0]  d;
  logic [31:0]          sig_sh;

  assign accept    = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;
  assign in_tready = !skid_valid_r;
  assign b         = in_tdata;

  assign pos_c    = CMP_W'(pos_r);
  assign len_c    = CMP_W'(len_r);
  assign nseg_c   = CMP_W'(nseg_r);
  assign file_end = (pos_c + CMP_W'(1)) >= len_c;
  assign seglen   = {seg_hi_r, b};
  assign seg_end  = nseg_c + CMP_W'(2) + CMP_W'(seglen);
  assign d        = pos_r - nseg_r;
  assign sig_sh   = {sig_r[23:0], b};

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    nseg_nxt   = nseg_r;
    sig_nxt    = sig_r;
    marker_nxt = marker_r;
    seg_hi_nxt = seg_hi_r;
    wacc_nxt   = wacc_r;
    hacc_nxt   = hacc_r;
    got        = 1'b0;
    res        = '{image_height: '0, image_width: '0,
                   status: ST_INCOMPLETE, format: FMT_JPEG};

    if (accept) begin
      unique case (phase_r)
        PH_HEAD: begin
          if (len_c < CMP_W'(HEAD_MIN_LEN)) begin
            got = 1'b1;
            res.format = FMT_UNKNOWN;
            res.status = ST_UNKNOWN_FMT;
          end else begin
            sig_nxt = sig_sh;
            if (pos_r == POS_BITS'(1) && sig_sh[15:0] == {BYTE_FF, JPEG_SOI}) begin
              phase_nxt = PH_JSEG;
              nseg_nxt  = POS_BITS'(2);
            end else if (pos_r == POS_BITS'(3)) begin
              if (sig_sh == PNG_SIG) begin
                if (len_c < CMP_W'(PNG_MIN_LEN)) begin
                  got = 1'b1;
                  res.format = FMT_PNG;
                  res.status = ST_PNG_SHORT;
                end else begin
                  phase_nxt = PH_PNG;
                end
              end else begin
                got = 1'b1;
                res.format = FMT_UNKNOWN;
                res.status = ST_UNKNOWN_FMT;
              end
            end
          end
        end
        PH_JSEG: begin
          if (pos_r == nseg_r) begin
            if (pos_c + CMP_W'(3) >= len_c) begin
              got = 1'b1;
              res.status = ST_OK_NO_SIZE;
            end else if (b != BYTE_FF) begin
              got = 1'b1;
              res.status = ST_MARKER_MISS;
            end else begin
              phase_nxt = PH_JMARK;
            end
          end
        end
        PH_JMARK: begin
          marker_nxt = b;
          phase_nxt  = PH_JLENHI;
        end
        PH_JLENHI: begin
          seg_hi_nxt = b;
          phase_nxt  = PH_JLENLO;
        end
        PH_JLENLO: begin
          // A length below 2 would never advance the walk, so it counts as incomplete.
          if (seglen < SEG_BITS'(2) || seg_end >= len_c) begin
            got = 1'b1;
            res.status = ST_INCOMPLETE;
          end else if (marker_r == JPEG_SOF0) begin
            if (nseg_c + CMP_W'(8) >= len_c) begin
              got = 1'b1;
              res.status = ST_INCOMPLETE;
            end else begin
              wacc_nxt  = '0;
              hacc_nxt  = '0;
              phase_nxt = PH_JSOF;
            end
          end else if (marker_r == JPEG_EOI || marker_r == JPEG_SOS) begin
            got = 1'b1;
            res.status = ST_SCAN_FIRST;
          end else begin
            nseg_nxt  = seg_end[POS_BITS-1:0];
            phase_nxt = PH_JSEG;
          end
        end
        PH_JSOF: begin
          // Height then width follow the precision byte, each 16 bits big-endian.
          if (d == POS_BITS'(5) || d == POS_BITS'(6)) begin
            hacc_nxt = {{(DIM_BITS-16){1'b0}}, hacc_r[7:0], b};
          end else if (d == POS_BITS'(7) || d == POS_BITS'(8)) begin
            wacc_nxt = {{(DIM_BITS-16){1'b0}}, wacc_r[7:0], b};
          end
          if (d == POS_BITS'(8)) begin
            got = 1'b1;
            res.status       = ST_SIZE_FOUND;
            res.image_width  = wacc_nxt;
            res.image_height = hacc_nxt;
          end
        end
        PH_PNG: begin
          if (pos_r >= POS_BITS'(PNG_TYPE_POS) && pos_r <= POS_BITS'(PNG_TYPE_END)) begin
            sig_nxt = sig_sh;
          end else if (pos_r >= POS_BITS'(PNG_WIDTH_POS) &&
                       pos_r <= POS_BITS'(PNG_WIDTH_END)) begin
            wacc_nxt = {wacc_r[DIM_BITS-9:0], b};
          end else if (pos_r >= POS_BITS'(PNG_HGT_POS) &&
                       pos_r <= POS_BITS'(PNG_HGT_END)) begin
            hacc_nxt = {hacc_r[DIM_BITS-9:0], b};
          end
          if (pos_r == POS_BITS'(PNG_TYPE_END) && sig_nxt != PNG_IHDR) begin
            got = 1'b1;
            res.format = FMT_PNG;
            res.status = ST_NO_IHDR;
          end else if (pos_r == POS_BITS'(PNG_HGT_END)) begin
            got = 1'b1;
            res.format       = FMT_PNG;
            res.status       = ST_SIZE_FOUND;
            res.image_width  = wacc_nxt;
            res.image_height = hacc_nxt;
          end
        end
        PH_DRAIN: begin
        end
        default: begin
        end
      endcase

      // The file ran out before any result was given.
      if (!got && phase_nxt != PH_DRAIN && file_end) begin
        got = 1'b1;
        if (phase_nxt == PH_HEAD) begin
          res.format = FMT_UNKNOWN;
          res.status = ST_UNKNOWN_FMT;
        end else if (phase_nxt == PH_PNG) begin
          res.format = FMT_PNG;
          res.status = ST_PNG_SHORT;
        end else begin
          res.format = FMT_JPEG;
          res.status = ST_INCOMPLETE;
        end
      end

      if (file_end) begin
        phase_nxt = PH_HEAD;
        pos_nxt   = '0;
        sig_nxt   = '0;
      end else begin
        pos_nxt = pos_r + POS_BITS'(1);
        if (got) begin
          phase_nxt = PH_DRAIN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      pos_r   <= '0;
      len_r   <= '0;
      sig_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sig_r   <= sig_nxt;
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    nseg_r   <= nseg_nxt;
    marker_r <= marker_nxt;
    seg_hi_r <= seg_hi_nxt;
    wacc_r   <= wacc_nxt;
    hacc_r   <= hacc_nxt;
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= got;
        out_r       <= res;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= got;
      out_r       <= res;
    end else if (got) begin
      skid_valid_r <= 1'b1;
      skid_r       <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_BITS-RES_BITS){1'b0}}, out_r};

  `IHSP_ASSERT(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r)
  `IHSP_ASSERT(a_stall_to_skid, clk, rst_n, (out_valid_r && !out_tready && got) |=> skid_valid_r)
  `IHSP_ASSERT(a_sof_window, clk, rst_n, (phase_r == PH_JSOF) |-> (d <= POS_BITS'(8)))
  `IHSP_ASSERT_RST(a_reset_clears, clk, !rst_n |=> (phase_r == PH_HEAD && !out_valid_r && !skid_valid_r))

endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the image header size parser: JPEG and PNG files, random stalls.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihsp_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [LEN_BITS-1:0] cfg_wr_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;      // [7:0] data_byte
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [1:0] format, [4:2] status, [36:5] image_width, [68:37] image_height, rest zero
  logic [OUT_BITS-1:0] out_tdata;

  image_header_size_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  logic [7:0] file_bytes_q[$];
  logic [7:0] file_buf[$];
  result_t    reports_due[$];
  int         issued_bytes = 0;
  int         taken_bytes = 0;
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_left = 0;
  bit         hold_req = 1'b0;

  // Parser shadow state.
  logic [LEN_BITS-1:0] file_len = '0;
  phase_t              hdr_phase = PH_HEAD;
  logic [POS_BITS-1:0] hdr_pos = '0;
  logic [POS_BITS-1:0] hdr_next = '0;
  logic [31:0]         hdr_sig = '0;
  logic [7:0]          hdr_marker = '0;
  logic [15:0]         hdr_seglen = '0;
  logic [31:0]         hdr_width = '0;
  logic [31:0]         hdr_height = '0;

  function automatic void clear_parse_state();
    hdr_phase  = PH_HEAD;
    hdr_pos    = '0;
    hdr_next   = '0;
    hdr_sig    = '0;
    hdr_marker = '0;
    hdr_seglen = '0;
    hdr_width  = '0;
    hdr_height = '0;
  endfunction

  function automatic result_t size_report(format_t fmt, status_t st, logic [31:0] w,
                                          logic [31:0] h);
    result_t r;
    r.format       = fmt;
    r.status       = st;
    r.image_width  = w;
    r.image_height = h;
    return r;
  endfunction

  // Advances the shadow parser by one byte; returns 1 when the byte completes a report.
  function automatic bit parse_byte(input logic [7:0] b, output result_t rep);
    bit got;
    logic [POS_BITS-1:0] d;
    got = 1'b0;
    rep = '0;
    case (hdr_phase)
      PH_HEAD: begin
        if (file_len < HEAD_MIN_LEN) begin
          rep = size_report(FMT_UNKNOWN, ST_UNKNOWN_FMT, 0, 0);
          got = 1'b1;
        end else begin
          hdr_sig = {hdr_sig[23:0], b};
          if (hdr_pos == 1 && hdr_sig[15:0] == {BYTE_FF, JPEG_SOI}) begin
            hdr_phase = PH_JSEG;
            hdr_next  = 2;
          end else if (hdr_pos == 3) begin
            if (hdr_sig == PNG_SIG) begin
              if (file_len < PNG_MIN_LEN) begin
                rep = size_report(FMT_PNG, ST_PNG_SHORT, 0, 0);
                got = 1'b1;
              end else begin
                hdr_phase = PH_PNG;
              end
            end else begin
              rep = size_report(FMT_UNKNOWN, ST_UNKNOWN_FMT, 0, 0);
              got = 1'b1;
            end
          end
        end
      end
      PH_JSEG: begin
        if (hdr_pos == hdr_next) begin
          if (hdr_pos + 3 >= file_len) begin
            rep = size_report(FMT_JPEG, ST_OK_NO_SIZE, 0, 0);
            got = 1'b1;
          end else if (b != BYTE_FF) begin
            rep = size_report(FMT_JPEG, ST_MARKER_MISS, 0, 0);
            got = 1'b1;
          end else begin
            hdr_phase = PH_JMARK;
          end
        end
      end
      PH_JMARK: begin
        hdr_marker = b;
        hdr_phase  = PH_JLENHI;
      end
      PH_JLENHI: begin
        hdr_seglen = {b, 8'h00};
        hdr_phase  = PH_JLENLO;
      end
      PH_JLENLO: begin
        hdr_seglen = {hdr_seglen[15:8], b};
        // The length check comes before the marker code is looked at.
        if (hdr_seglen < 2 || hdr_next + 2 + hdr_seglen >= file_len) begin
          rep = size_report(FMT_JPEG, ST_INCOMPLETE, 0, 0);
          got = 1'b1;
        end else if (hdr_marker == JPEG_SOF0) begin
          if (hdr_next + 8 >= file_len) begin
            rep = size_report(FMT_JPEG, ST_INCOMPLETE, 0, 0);
            got = 1'b1;
          end else begin
            hdr_width  = '0;
            hdr_height = '0;
            hdr_phase  = PH_JSOF;
          end
        end else if (hdr_marker == JPEG_EOI || hdr_marker == JPEG_SOS) begin
          rep = size_report(FMT_JPEG, ST_SCAN_FIRST, 0, 0);
          got = 1'b1;
        end else begin
          hdr_next  = POS_BITS'(hdr_next + 2 + hdr_seglen);
          hdr_phase = PH_JSEG;
        end
      end
      PH_JSOF: begin
        d = hdr_pos - hdr_next;
        if (d == 5 || d == 6)
          hdr_height = {16'h0000, hdr_height[7:0], b};
        else if (d == 7 || d == 8)
          hdr_width = {16'h0000, hdr_width[7:0], b};
        if (d == 8) begin
          rep = size_report(FMT_JPEG, ST_SIZE_FOUND, hdr_width, hdr_height);
          got = 1'b1;
        end
      end
      PH_PNG: begin
        if (hdr_pos >= PNG_TYPE_POS && hdr_pos <= PNG_TYPE_END)
          hdr_sig = {hdr_sig[23:0], b};
        else if (hdr_pos >= PNG_WIDTH_POS && hdr_pos <= PNG_WIDTH_END)
          hdr_width = {hdr_width[23:0], b};
        else if (hdr_pos >= PNG_HGT_POS && hdr_pos <= PNG_HGT_END)
          hdr_height = {hdr_height[23:0], b};
        if (hdr_pos == PNG_TYPE_END && hdr_sig != PNG_IHDR) begin
          rep = size_report(FMT_PNG, ST_NO_IHDR, 0, 0);
          got = 1'b1;
        end else if (hdr_pos == PNG_HGT_END) begin
          rep = size_report(FMT_PNG, ST_SIZE_FOUND, hdr_width, hdr_height);
          got = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // The file ran out before any report was given.
    if (!got && hdr_phase != PH_DRAIN && hdr_pos + 1 >= file_len) begin
      if (hdr_phase == PH_HEAD)
        rep = size_report(FMT_UNKNOWN, ST_UNKNOWN_FMT, 0, 0);
      else if (hdr_phase == PH_PNG)
        rep = size_report(FMT_PNG, ST_PNG_SHORT, 0, 0);
      else
        rep = size_report(FMT_JPEG, ST_INCOMPLETE, 0, 0);
      got = 1'b1;
    end

    if (hdr_pos + 1 >= file_len) begin
      clear_parse_state();
    end else begin
      hdr_pos = hdr_pos + 1'b1;
      if (got)
        hdr_phase = PH_DRAIN;
    end
    return got;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
      errors++;
    end
  endtask

  // Byte driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (file_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= file_bytes_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Accepted bytes feed the shadow parser.
  always @(posedge clk) begin
    result_t rep;
    if (rst_n && in_tvalid && in_tready) begin
      taken_bytes++;
      if (parse_byte(in_tdata, rep))
        reports_due.push_back(rep);
    end
  end

  // Report sink with random stalls and a single long hold-off.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = result_t'(out_tdata[RES_BITS-1:0]);
      if (reports_due.size() == 0) begin
        $error("report with none expected: 0x%0h", out_tdata);
        errors++;
      end else begin
        want = reports_due.pop_front();
        check_field("format", want.format, seen.format);
        check_field("status", want.status, seen.status);
        check_field("image_width", want.image_width, seen.image_width);
        check_field("image_height", want.image_height, seen.image_height);
        check_field("padding", 0, out_tdata[OUT_BITS-1:RES_BITS]);
      end
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (taken_bytes != issued_bytes || reports_due.size() != 0)
      @(posedge clk);
    // Room for a report of the last byte and for a byte that gives none.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input int len);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LEN_BITS'(len);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    file_len = LEN_BITS'(len);
  endtask

  // Queues the built bytes, padded with random ones or cut to n.
  task automatic send_bytes(input int n);
    for (int i = 0; i < n; i++)
      file_bytes_q.push_back((i < file_buf.size()) ? file_buf[i] : 8'($urandom));
    issued_bytes += n;
    file_buf.delete();
  endtask

  task automatic send_file(input int len);
    wait_idle();
    write_length(len);
    send_bytes((len == 0) ? 1 : len);
  endtask

  function automatic logic [7:0] plain_marker();
    logic [7:0] m;
    m = 8'($urandom);
    if (m == JPEG_SOF0 || m == JPEG_EOI || m == JPEG_SOS)
      m = 8'hE0;
    return m;
  endfunction

  function automatic void put_seg(logic [7:0] marker, logic [15:0] seglen, int plen);
    file_buf.push_back(BYTE_FF);
    file_buf.push_back(marker);
    file_buf.push_back(seglen[15:8]);
    file_buf.push_back(seglen[7:0]);
    repeat (plen) file_buf.push_back(8'($urandom));
  endfunction

  function automatic void put_sof(logic [15:0] seglen, logic [15:0] w, logic [15:0] h);
    put_seg(JPEG_SOF0, seglen, 0);
    file_buf.push_back(8'd8);
    file_buf.push_back(h[15:8]);
    file_buf.push_back(h[7:0]);
    file_buf.push_back(w[15:8]);
    file_buf.push_back(w[7:0]);
    repeat ((seglen > 7) ? seglen - 7 : 0) file_buf.push_back(8'($urandom));
  endfunction

  function automatic void put_png(logic [31:0] w, logic [31:0] h, bit bad_type);
    logic [31:0] ctype;
    ctype = PNG_IHDR;
    if (bad_type)
      ctype[8*$urandom_range(3) +: 8] = 8'($urandom);
    file_buf = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
                 8'h00, 8'h00, 8'h00, 8'h0D};
    for (int i = 3; i >= 0; i--) file_buf.push_back(ctype[8*i +: 8]);
    for (int i = 3; i >= 0; i--) file_buf.push_back(w[8*i +: 8]);
    for (int i = 3; i >= 0; i--) file_buf.push_back(h[8*i +: 8]);
  endfunction

  // Mostly well-formed files with random content; the rest are broken or noise.
  task automatic build_random_file(output int flen);
    int kind;
    int plen;
    kind = $urandom_range(99);
    file_buf.delete();
    if (kind >= 60 && kind < 80) begin
      put_png($urandom, $urandom, $urandom_range(9) == 0);
      flen = ($urandom_range(9) == 0) ? $urandom_range(4, 23) : 24 + $urandom_range(8);
    end else if (kind >= 90) begin
      flen = $urandom_range(30);
      if ($urandom_range(1) == 1)
        file_buf = '{BYTE_FF, JPEG_SOI};
    end else begin
      file_buf = '{BYTE_FF, JPEG_SOI};
      repeat ($urandom_range(3)) begin
        plen = $urandom_range(6);
        put_seg(plain_marker(), 16'(plen + 2), plen);
      end
      if (kind < 40 || kind >= 80) begin
        put_sof(($urandom_range(9) == 0) ? 16'($urandom_range(20)) : 16'($urandom_range(8, 17)),
                16'($urandom), 16'($urandom));
      end else if (kind < 50) begin
        plen = $urandom_range(4);
        put_seg(($urandom_range(1) == 1) ? JPEG_SOS : JPEG_EOI, 16'(plen + 2), plen);
      end
      flen = file_buf.size() + $urandom_range((kind >= 50 && kind < 60) ? 0 : 1, 5);
      if (kind >= 80) begin
        file_buf[$urandom_range(file_buf.size() - 1)] = 8'($urandom);
        if ($urandom_range(1) == 1)
          flen = $urandom_range(4, flen);
      end
    end
  endtask

  initial begin
    int flen;
    int rand_bytes;
    clear_parse_state();
    rand_bytes    = 0;
    send_idle_pct = 6;
    recv_idle_pct = 45;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Zero length: every byte is a file of its own.
    send_file(0);
    send_file(3);
    file_buf = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_file(4);
    file_buf = '{8'h89, 8'h50, 8'h4E, 8'h00};
    send_file(6);
    // Size found: largest sizes after one plain segment, smallest sizes with no segment before.
    file_buf = '{BYTE_FF, JPEG_SOI};
    put_seg(8'hE0, 16'd4, 2);
    put_sof(16'd17, 16'hFFFF, 16'hFFFF);
    send_file(file_buf.size() + 2);
    file_buf = '{BYTE_FF, JPEG_SOI};
    put_sof(16'd8, 16'h0000, 16'h0000);
    send_file(file_buf.size() + 1);
    // Missing marker prefix.
    file_buf = '{BYTE_FF, JPEG_SOI, 8'h00, 8'hE0};
    send_file(10);
    // Segment lengths of 0 and 1, and one running past the end.
    file_buf = '{BYTE_FF, JPEG_SOI, BYTE_FF, 8'hE0, 8'h00, 8'h00};
    send_file(20);
    file_buf = '{BYTE_FF, JPEG_SOI, BYTE_FF, 8'hE0, 8'h00, 8'h01};
    send_file(20);
    file_buf = '{BYTE_FF, JPEG_SOI, BYTE_FF, 8'hE0, 8'h00, 8'h10};
    send_file(10);
    // Scan start and end of image before any size.
    file_buf = '{BYTE_FF, JPEG_SOI, BYTE_FF, JPEG_SOS, 8'h00, 8'h04};
    send_file(12);
    file_buf = '{BYTE_FF, JPEG_SOI, BYTE_FF, JPEG_EOI, 8'h00, 8'h02};
    send_file(10);
    // The walk runs out of file at a segment start.
    file_buf = '{BYTE_FF, JPEG_SOI, BYTE_FF, 8'hE0};
    send_file(4);
    // Start of frame whose size bytes lie past the end.
    file_buf = '{BYTE_FF, JPEG_SOI, BYTE_FF, JPEG_SOF0, 8'h00, 8'h02};
    send_file(8);
    put_png(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_file(24);
    put_png(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_file(23);
    put_png(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    send_file(30);
    // Largest length: the report comes early, then a length of 1 ends the drain.
    file_buf = '{BYTE_FF, JPEG_SOI};
    put_sof(16'd11, 16'h0280, 16'h01E0);
    wait_idle();
    write_length(24'hFF_FFFF);
    send_bytes(file_buf.size() + 3);
    send_file(1);
    put_png(32'h0000_0780, 32'h0000_0438, 1'b0);
    wait_idle();
    write_length(24'hFF_FFFF);
    send_bytes(28);
    send_file(1);

    // One-byte files while the sink holds off: the block has to stall its input.
    wait_idle();
    write_length(1);
    hold_req = 1'b1;
    send_bytes(40);

    while (rand_bytes < 940) begin
      if (rand_bytes < 310) begin
        send_idle_pct = 6;
        recv_idle_pct = 45;
      end else if (rand_bytes < 620) begin
        send_idle_pct = 45;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      build_random_file(flen);
      send_file(flen);
      rand_bytes += (flen == 0) ? 1 : flen;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ihsp_pkg.sv
hw/rtl/image_header_size_parser.sv
verif/tb.sv
